// ===== hw/rtl/bfa_pkg.sv =====
// Shared types, constants and helpers for the bitmap frame allocator.
`default_nettype none
package bfa_pkg;

  // Map geometry
  localparam int unsigned NumFrames   = 131072;
  localparam int unsigned MapWordBits = 64;
  localparam int unsigned FrameW      = $clog2(NumFrames);
  localparam int unsigned BitW        = $clog2(MapWordBits);
  localparam int unsigned MapWords    = NumFrames / MapWordBits;
  localparam int unsigned WordW       = FrameW - BitW;

  // Frame and field sizes
  localparam int unsigned FrameShift  = 12;
  localparam int unsigned CountW      = 32;
  localparam int unsigned FrameAddrW  = 29;
  localparam int unsigned BytesW      = 44;
  localparam logic [CountW-1:0] CountMax = '1;

  // Opcodes
  localparam logic [1:0] OpAlloc   = 2'd0;
  localparam logic [1:0] OpFree    = 2'd1;
  localparam logic [1:0] OpRelease = 2'd2;

  // Result status codes
  localparam logic [1:0] StDone     = 2'd0;
  localparam logic [1:0] StOom      = 2'd1;
  localparam logic [1:0] StNoChange = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] address;
    logic [63:0] length;
    logic        region_usable;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [FrameAddrW-1:0] frame_address;
    logic [BytesW-1:0]     free_bytes;
    logic [BytesW-1:0]     total_bytes;
  } out_item_t;

  // Map memory access from the engine
  typedef struct packed {
    logic                   re;
    logic                   we;
    logic [WordW-1:0]       addr;
    logic [MapWordBits-1:0] wdata;
  } mem_req_t;

  // Lowest set bit position of a map word
  function automatic logic [BitW-1:0] first_one(input logic [MapWordBits-1:0] v);
    logic [BitW-1:0] pos;
    pos = '0;
    for (int i = MapWordBits - 1; i >= 0; i--) begin
      if (v[i]) pos = BitW'(i);
    end
    return pos;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bfa_map_store.sv =====
// Used-map memory with registered read and post-reset fill to all ones.
`default_nettype none
module bfa_map_store (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire bfa_pkg::mem_req_t               req_i,
  output logic [bfa_pkg::MapWordBits-1:0]      rdata_o,
  output logic                                 init_done_o
);

  logic [bfa_pkg::MapWordBits-1:0] mem_q [bfa_pkg::MapWords];
  logic [bfa_pkg::WordW-1:0]       init_cnt_q, init_cnt_d;
  logic                            init_busy_q, init_busy_d;

  // Fill sweep: one word per cycle after reset
  always_comb begin
    init_cnt_d  = init_cnt_q;
    init_busy_d = init_busy_q;
    if (init_busy_q) begin
      init_cnt_d = init_cnt_q + 1'b1;
      if (init_cnt_q == bfa_pkg::WordW'(bfa_pkg::MapWords - 1)) init_busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cnt_q  <= '0;
      init_busy_q <= 1'b1;
    end else begin
      init_cnt_q  <= init_cnt_d;
      init_busy_q <= init_busy_d;
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (init_busy_q) begin
      mem_q[init_cnt_q] <= '1;
    end else if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) rdata_o <= mem_q[req_i.addr];
  end

  assign init_done_o = !init_busy_q;

endmodule
`default_nettype wire

// ===== hw/rtl/bfa_engine.sv =====
// Allocator sequencer: decodes an item, walks map words read-modify-write, keeps counters.
`default_nettype none
module bfa_engine (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        init_done_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire bfa_pkg::in_item_t           in_data_i,
  output logic                             res_valid_o,
  input  wire logic                        res_ready_i,
  output bfa_pkg::out_item_t               res_o,
  output bfa_pkg::mem_req_t                req_o,
  input  wire logic [bfa_pkg::MapWordBits-1:0] rdata_i
);

  localparam int unsigned MW = bfa_pkg::MapWordBits;
  localparam int unsigned FW = bfa_pkg::FrameW;
  localparam int unsigned BW = bfa_pkg::BitW;
  localparam int unsigned WW = bfa_pkg::WordW;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PREP1 = 7'b0000010,
    S_PREP2 = 7'b0000100,
    S_PREP3 = 7'b0001000,
    S_RD    = 7'b0010000,
    S_CHK   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  bfa_pkg::in_item_t item_q, item_d;
  logic [63:0]       sum_q, sum_d;
  logic [63:0]       rem_q, rem_d;
  logic              empty_q, empty_d;
  logic [51:0]       first52_q, first52_d;
  logic [52:0]       endr_q, endr_d;
  logic [FW-1:0]     first_q, first_d;
  logic [FW-1:0]     last_q, last_d;
  logic [FW:0]       cnt_q, cnt_d;
  logic [WW-1:0]     word_q, word_d;
  logic [BW-1:0]     bit_q, bit_d;

  logic [bfa_pkg::CountW-1:0] free_q, free_d;
  logic [bfa_pkg::CountW-1:0] total_q, total_d;
  logic [FW-1:0]              high_q, high_d;
  logic [1:0]                 status_q, status_d;
  logic [FW-1:0]              fidx_q, fidx_d;

  // Combinational helpers
  logic [11:0]       low;
  logic [12:0]       adj;
  logic [64:0]       sum65;
  logic [64:0]       rem65;
  logic [52:0]       end_c;
  logic [MW-1:0]     ones;
  logic [BW-1:0]     lo_b, hi_b, ahi_b;
  logic [MW-1:0]     rmask, vmask, cand;
  logic [BW-1:0]     fbit;
  logic [bfa_pkg::CountW:0] free_sum, total_sum;
  logic [63:0]       fa64;

  always_comb begin
    ones   = '1;
    low    = item_q.address[11:0];
    adj    = (low != 12'd0) ? (13'd4096 - {1'b0, low}) : 13'd0;
    sum65  = {1'b0, item_q.address} + {52'd0, adj};
    rem65  = {1'b0, item_q.length} - {52'd0, adj};
    end_c  = (endr_q > 53'(bfa_pkg::NumFrames)) ? 53'(bfa_pkg::NumFrames) : endr_q;
    // Release clear mask within the current word
    lo_b   = (word_q == first_q[FW-1:BW]) ? first_q[BW-1:0] : '0;
    hi_b   = (word_q == last_q[FW-1:BW]) ? last_q[BW-1:0] : '1;
    rmask  = (ones << lo_b) & (ones >> (BW'(MW - 1) - hi_b));
    // Allocate search limit within the current word
    ahi_b  = (word_q == high_q[FW-1:BW]) ? high_q[BW-1:0] : '1;
    vmask  = ones >> (BW'(MW - 1) - ahi_b);
    cand   = ~rdata_i & vmask;
    fbit   = bfa_pkg::first_one(cand);
    free_sum  = {1'b0, free_q} + (bfa_pkg::CountW + 1)'(cnt_q);
    total_sum = {1'b0, total_q} + (bfa_pkg::CountW + 1)'(cnt_q);
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    sum_d     = sum_q;
    rem_d     = rem_q;
    empty_d   = empty_q;
    first52_d = first52_q;
    endr_d    = endr_q;
    first_d   = first_q;
    last_d    = last_q;
    cnt_d     = cnt_q;
    word_d    = word_q;
    bit_d     = bit_q;
    free_d    = free_q;
    total_d   = total_q;
    high_d    = high_q;
    status_d  = status_q;
    fidx_d    = fidx_q;
    req_o     = '0;
    req_o.addr = word_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i && init_done_i) begin
          item_d  = in_data_i;
          state_d = S_PREP1;
        end
      end
      S_PREP1: begin
        status_d = bfa_pkg::StNoChange;
        fidx_d   = '0;
        sum_d    = sum65[63:0];
        rem_d    = rem65[63:0];
        empty_d  = sum65[64] || rem65[64];
        if (item_q.opcode == bfa_pkg::OpAlloc) begin
          word_d  = '0;
          state_d = S_RD;
        end else if (item_q.opcode == bfa_pkg::OpFree) begin
          if (item_q.address[63:12] < 52'(bfa_pkg::NumFrames)) begin
            word_d  = item_q.address[12 + FW - 1:12 + BW];
            bit_d   = item_q.address[12 + BW - 1:12];
            state_d = S_RD;
          end else begin
            state_d = S_DONE;
          end
        end else if (item_q.opcode == bfa_pkg::OpRelease && item_q.region_usable) begin
          state_d = S_PREP2;
        end else begin
          state_d = S_DONE;
        end
      end
      S_PREP2: begin
        first52_d = sum_q[63:12];
        endr_d    = {1'b0, sum_q[63:12]} + {1'b0, rem_q[63:12]};
        state_d   = S_PREP3;
      end
      S_PREP3: begin
        if (empty_q || ({1'b0, first52_q} >= end_c)) begin
          state_d = S_DONE;
        end else begin
          first_d = first52_q[FW-1:0];
          last_d  = FW'(end_c - 53'd1);
          cnt_d   = (FW + 1)'(end_c - {1'b0, first52_q});
          word_d  = first52_q[FW-1:BW];
          state_d = S_RD;
        end
      end
      S_RD: begin
        req_o.re = 1'b1;
        state_d  = S_CHK;
      end
      S_CHK: begin
        if (item_q.opcode == bfa_pkg::OpAlloc) begin
          if (cand != '0) begin
            req_o.we    = 1'b1;
            req_o.wdata = rdata_i | (MW'(1) << fbit);
            if (free_q != '0) free_d = free_q - 1'b1;
            fidx_d   = {word_q, fbit};
            status_d = bfa_pkg::StDone;
            state_d  = S_DONE;
          end else if (word_q == high_q[FW-1:BW]) begin
            status_d = bfa_pkg::StOom;
            state_d  = S_DONE;
          end else begin
            word_d  = word_q + 1'b1;
            state_d = S_RD;
          end
        end else if (item_q.opcode == bfa_pkg::OpFree) begin
          if (rdata_i[bit_q]) begin
            req_o.we    = 1'b1;
            req_o.wdata = rdata_i & ~(MW'(1) << bit_q);
            if (free_q != bfa_pkg::CountMax) free_d = free_q + 1'b1;
            status_d = bfa_pkg::StDone;
          end
          state_d = S_DONE;
        end else begin
          // Release sweep
          req_o.we    = 1'b1;
          req_o.wdata = rdata_i & ~rmask;
          if (word_q == last_q[FW-1:BW]) begin
            free_d   = free_sum[bfa_pkg::CountW] ? bfa_pkg::CountMax
                                                 : free_sum[bfa_pkg::CountW-1:0];
            total_d  = total_sum[bfa_pkg::CountW] ? bfa_pkg::CountMax
                                                  : total_sum[bfa_pkg::CountW-1:0];
            if (last_q > high_q) high_d = last_q;
            status_d = bfa_pkg::StDone;
            state_d  = S_DONE;
          end else begin
            word_d  = word_q + 1'b1;
            state_d = S_RD;
          end
        end
      end
      S_DONE: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      free_q  <= '0;
      total_q <= '0;
      high_q  <= '0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      total_q <= total_d;
      high_q  <= high_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    sum_q     <= sum_d;
    rem_q     <= rem_d;
    empty_q   <= empty_d;
    first52_q <= first52_d;
    endr_q    <= endr_d;
    first_q   <= first_d;
    last_q    <= last_d;
    cnt_q     <= cnt_d;
    word_q    <= word_d;
    bit_q     <= bit_d;
    status_q  <= status_d;
    fidx_q    <= fidx_d;
  end

  // Result
  always_comb begin
    fa64                = 64'(fidx_q) << bfa_pkg::FrameShift;
    in_ready_o          = (state_q == S_IDLE) && init_done_i;
    res_valid_o         = (state_q == S_DONE);
    res_o.status        = status_q;
    res_o.frame_address = fa64[bfa_pkg::FrameAddrW-1:0];
    res_o.free_bytes    = {free_q, 12'd0};
    res_o.total_bytes   = {total_q, 12'd0};
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bitmap_frame_allocator_top.sv =====
// Top level: bitmap frame allocator with map memory, sequencer and output register.
// One item in work at a time; throughput is set by the read-modify-write loop on the map port.
// Reset: counters clear at once; the map is filled to all-used, one word a cycle, during
// which no item is accepted.
`default_nettype none
module bitmap_frame_allocator_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire bfa_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output bfa_pkg::out_item_t      out_data_o
);

  bfa_pkg::mem_req_t               req;
  logic [bfa_pkg::MapWordBits-1:0] rdata;
  logic                            init_done;
  logic                            res_valid, res_ready;
  bfa_pkg::out_item_t              res;
  logic                            out_valid_q, out_valid_d;
  bfa_pkg::out_item_t              out_q;

  bfa_map_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .rdata_o     (rdata),
    .init_done_o (init_done)
  );

  bfa_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_done_i (init_done),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .req_o       (req),
    .rdata_i     (rdata)
  );

  // Output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (res_valid && res_ready) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== hw/rtl/bfa_checker.sv =====
// Port-level checks for the bitmap frame allocator, bound to the top level.
`default_nettype none
module bfa_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire bfa_pkg::out_item_t out_data_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Status is always a defined code
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == bfa_pkg::StDone ||
                     out_data_o.status == bfa_pkg::StOom ||
                     out_data_o.status == bfa_pkg::StNoChange))
    else $error("undefined status");

  // Frame address is frame aligned, and zero when out of memory
  a_faddr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.frame_address[11:0] == 12'd0) &&
      (out_data_o.status != bfa_pkg::StOom || out_data_o.frame_address == '0))
    else $error("bad frame address");

  // Byte counts are whole frames
  a_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.free_bytes[11:0] == 12'd0) &&
      (out_data_o.total_bytes[11:0] == 12'd0))
    else $error("byte count not frame aligned");

endmodule

bind bitmap_frame_allocator_top bfa_checker u_bfa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
